// ===== rtl/core/tcat_pkg.sv =====
// tcat_pkg: shared types and codes for the time-crossing alarm table.
// Used by tcat_mem, tcat_cross and time_crossing_alarm_table.
`timescale 1ns / 1ps

package tcat_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int MAX_RES   = 16;
    localparam int NFW       = 5;

    // operation codes
    localparam logic [2:0] FN_ALLOC  = 3'd0;
    localparam logic [2:0] FN_FREE   = 3'd1;
    localparam logic [2:0] FN_DISARM = 3'd2;
    localparam logic [2:0] FN_ARM    = 3'd3;
    localparam logic [2:0] FN_ADV    = 3'd4;
    localparam logic [2:0] FN_REL    = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PARAM = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;
    localparam logic [1:0] DIR_BOTH = 2'd3;

    // one table entry as stored in memory
    typedef struct packed {
        logic [7:0]  movie;
        logic [15:0] handler;
        logic [31:0] ctx;
        logic [1:0]  dir;
        logic [30:0] atime;
        logic [30:0] scale;
    } t_entry;

    // one request word
    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  slot;
        logic [7:0]  movie;
        logic [15:0] handler;
        logic [31:0] ctx;
        logic [1:0]  dir;
        logic [31:0] atime;
        logic [31:0] ascale;
        logic [31:0] start_time;
        logic [31:0] after;
        logic [30:0] mscale;
    } t_req;

    // one result word
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic        fired;
        logic [15:0] handler;
        logic [31:0] ctx;
        logic        last;
    } t_rsp;

    // crossing pipeline status
    typedef struct packed {
        logic a_vld;
        logic b_vld;
        logic hit;
    } t_xstat;

endpackage

// ===== rtl/core/tcat_mem.sv =====
// tcat_mem: alarm entry store, one write port and one registered read port.
// Depends on tcat_pkg for the entry type.
`timescale 1ns / 1ps

module tcat_mem #(
    parameter int DEPTH = tcat_pkg::SLOTS_DEF,
    parameter int IW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IW-1:0]   i_waddr,
    input  tcat_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [IW-1:0]   i_raddr,
    output tcat_pkg::t_entry o_rdata
);
    import tcat_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tcat_cross.sv =====
// tcat_cross: two-stage crossing test of one entry (products, then compares).
// Depends on tcat_pkg; fed by the scan in time_crossing_alarm_table.
`timescale 1ns / 1ps

module tcat_cross #(
    parameter int IW = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic             i_elig,
    input  logic [IW-1:0]    i_idx,
    input  tcat_pkg::t_entry i_entry,
    input  logic [31:0]      i_before,
    input  logic [31:0]      i_after,
    input  logic [30:0]      i_mscale,
    output tcat_pkg::t_xstat o_xst,
    output logic [IW-1:0]    o_idx,
    output tcat_pkg::t_entry o_entry
);
    import tcat_pkg::*;

    logic [61:0]        w_tgt;
    logic signed [63:0] w_prev;
    logic signed [63:0] w_cur;
    logic signed [63:0] w_tgt_s;

    logic               r_a_vld;
    logic               r_a_elig;
    logic [IW-1:0]      r_a_idx;
    t_entry             r_a_entry;
    logic [61:0]        r_a_tgt;
    logic signed [63:0] r_a_prev;
    logic signed [63:0] r_a_cur;

    logic               r_b_vld;
    logic               r_b_hit;
    logic [IW-1:0]      r_b_idx;
    t_entry             r_b_entry;

    // stage A: three independent products
    assign w_tgt  = i_entry.atime * i_mscale;
    assign w_prev = $signed(i_before) * $signed({1'b0, i_entry.scale});
    assign w_cur  = $signed(i_after) * $signed({1'b0, i_entry.scale});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_elig  <= i_elig;
            r_a_idx   <= i_idx;
            r_a_entry <= i_entry;
            r_a_tgt   <= w_tgt;
            r_a_prev  <= w_prev;
            r_a_cur   <= w_cur;
        end
    end

    // stage B: forward crossing compares
    assign w_tgt_s = $signed({2'b00, r_a_tgt});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_hit   <= r_a_vld && r_a_elig && (r_a_cur > r_a_prev) &&
                         (r_a_prev <= w_tgt_s) && (w_tgt_s <= r_a_cur);
            r_b_idx   <= r_a_idx;
            r_b_entry <= r_a_entry;
        end
    end

    assign o_xst.a_vld = r_a_vld;
    assign o_xst.b_vld = r_b_vld;
    assign o_xst.hit   = r_b_vld && r_b_hit;
    assign o_idx       = r_b_idx;
    assign o_entry     = r_b_entry;

endmodule

// ===== rtl/core/time_crossing_alarm_table.sv =====
// Time-crossing alarm table. Free and release-all answer straight from idle; disarm
// and arm pass the write state first; allocate walks the valid bits one slot a cycle.
// Release of one movie scans the entry memory one slot a cycle; advance adds the
// two crossing stages to the scan and can stall on the result side. A new word is
// accepted once the previous item's results are all queued. Synchronous active-low
// reset clears all valid bits; no clearing pass.
`timescale 1ns / 1ps

module time_crossing_alarm_table #(
    parameter int SLOTS = tcat_pkg::SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // slot, movie_id, handler, user_context, dir_mode, alarm_time,
    // alarm_scale, before_time, after_time, media_scale, zero pad
    input  logic [223:0] i_s_axis_tdata,
    // func
    input  logic [2:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // status, out_slot, fired_handler, fired_context, zero pad
    output logic [55:0]  o_m_axis_tdata,
    // fired
    output logic [0:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast
);
    import tcat_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] CntEnd = CW'(SLOTS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ALLOC = 5'b00010,
        S_WR    = 5'b00100,
        S_SCAN  = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    t_state         r_state;
    t_req           r_req;
    logic [SLOTS-1:0] r_valid;
    logic [CW-1:0]  r_cnt;
    logic           r_s1_vld;
    logic [IW-1:0]  r_s1_idx;
    logic [NFW-1:0] r_nfire;
    logic           r_pend_vld;
    t_rsp           r_pend;
    t_rsp           r_rsp;
    t_rsp           r_out;
    logic           r_out_vld;

    t_req           w_req;
    logic           w_acc;
    logic           w_out_free;
    logic           w_out_load;
    t_rsp           w_out_next;
    logic           w_now_inrange;
    logic [IW-1:0]  w_now_idx;
    logic           w_inrange;
    logic [IW-1:0]  w_sidx;
    logic [IW-1:0]  w_cidx;
    logic           w_is_adv;
    logic           w_arm_ok;
    logic           w_issue;
    logic           w_s1_elig;
    logic           w_fire;
    logic           w_stall;
    logic           w_done;

    logic           w_we;
    logic [IW-1:0]  w_waddr;
    t_entry         w_wdata;
    logic           w_re;
    logic [IW-1:0]  w_raddr;
    t_entry         w_rdata;

    t_xstat         w_xst;
    logic [IW-1:0]  w_b_idx;
    t_entry         w_b_entry;

    // unpack the input word
    assign w_req.func       = i_s_axis_tuser;
    assign w_req.slot       = i_s_axis_tdata[3:0];
    assign w_req.movie      = i_s_axis_tdata[11:4];
    assign w_req.handler    = i_s_axis_tdata[27:12];
    assign w_req.ctx        = i_s_axis_tdata[59:28];
    assign w_req.dir        = i_s_axis_tdata[61:60];
    assign w_req.atime      = i_s_axis_tdata[93:62];
    assign w_req.ascale     = i_s_axis_tdata[125:94];
    assign w_req.start_time = i_s_axis_tdata[157:126];
    assign w_req.after      = i_s_axis_tdata[189:158];
    assign w_req.mscale     = i_s_axis_tdata[220:190];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_vld || i_m_axis_tready;

    // slot decode
    assign w_now_inrange = (32'(w_req.slot) < 32'(SLOTS));
    assign w_now_idx     = IW'(w_req.slot);
    assign w_inrange     = (32'(r_req.slot) < 32'(SLOTS));
    assign w_sidx        = IW'(r_req.slot);
    assign w_cidx        = r_cnt[IW-1:0];
    assign w_is_adv      = (r_req.func == FN_ADV);

    assign w_arm_ok = w_inrange && r_valid[w_sidx] && (r_req.handler != 16'd0) &&
                      !r_req.ascale[31] && (r_req.ascale != 32'd0) &&
                      !r_req.atime[31] && (r_req.dir != DIR_NONE);

    // scan pipeline control
    assign w_issue   = (r_state == S_SCAN) && (r_cnt != CntEnd);
    assign w_s1_elig = r_s1_vld && r_valid[r_s1_idx] && (w_rdata.movie == r_req.movie) &&
                       (w_rdata.handler != 16'd0) && (w_rdata.dir != DIR_BACK);
    assign w_fire    = w_xst.hit && (r_nfire < NFW'(MAX_RES));
    assign w_stall   = w_fire && r_pend_vld && !w_out_free;
    assign w_done    = (r_state == S_SCAN) && !w_issue && !r_s1_vld &&
                       !w_xst.a_vld && !w_xst.b_vld;

    // memory read port
    assign w_re = (w_acc && ((w_req.func == FN_DISARM) || (w_req.func == FN_ARM))) ||
                  (w_issue && !w_stall);
    assign w_raddr = (r_state == S_IDLE) ? w_now_idx : w_cidx;

    // memory write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_sidx;
        w_wdata = w_rdata;
        case (r_state)
            S_ALLOC: begin
                w_we          = (r_cnt != CntEnd) && !r_valid[w_cidx];
                w_waddr       = w_cidx;
                w_wdata.movie = r_req.movie;
                w_wdata.handler = 16'd0;
                w_wdata.ctx   = 32'd0;
                w_wdata.dir   = DIR_FWD;
                w_wdata.atime = 31'd0;
                w_wdata.scale = 31'd1;
            end
            S_WR: begin
                if (r_req.func == FN_ARM) begin
                    w_we            = w_arm_ok;
                    w_wdata.handler = r_req.handler;
                    w_wdata.ctx     = r_req.ctx;
                    w_wdata.dir     = r_req.dir;
                    w_wdata.atime   = r_req.atime[30:0];
                    w_wdata.scale   = r_req.ascale[30:0];
                end else begin
                    w_we            = w_inrange && r_valid[w_sidx];
                    w_wdata.handler = 16'd0;
                end
            end
            S_SCAN: begin
                w_we            = w_fire && !w_stall;
                w_waddr         = w_b_idx;
                w_wdata         = w_b_entry;
                w_wdata.handler = 16'd0;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    tcat_mem #(
        .DEPTH (SLOTS),
        .IW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tcat_cross #(
        .IW (IW)
    ) u_cross (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (!w_stall),
        .i_vld    (r_s1_vld && w_is_adv && (r_state == S_SCAN)),
        .i_elig   (w_s1_elig),
        .i_idx    (r_s1_idx),
        .i_entry  (w_rdata),
        .i_before (r_req.start_time),
        .i_after  (r_req.after),
        .i_mscale (r_req.mscale),
        .o_xst    (w_xst),
        .o_idx    (w_b_idx),
        .o_entry  (w_b_entry)
    );

    // output register load
    assign w_out_load = ((r_state == S_RESP) && w_out_free) ||
                        ((r_state == S_SCAN) && w_fire && !w_stall && r_pend_vld);
    assign w_out_next = (r_state == S_RESP) ? r_rsp : r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_out_next;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_cnt      <= '0;
            r_s1_vld   <= 1'b0;
            r_nfire    <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_req   <= w_req;
                        r_cnt   <= '0;
                        r_nfire <= '0;
                        // unknown func answers a parameter error
                        r_rsp   <= '{status: (w_req.func > FN_REL) ? ST_PARAM : ST_OK,
                                     slot: 4'd0, fired: 1'b0,
                                     handler: 16'd0, ctx: 32'd0, last: 1'b1};
                        case (w_req.func)
                            FN_ALLOC: begin
                                r_state <= S_ALLOC;
                            end
                            FN_FREE: begin
                                if (w_now_inrange) begin
                                    r_valid[w_now_idx] <= 1'b0;
                                end
                                r_state <= S_RESP;
                            end
                            FN_DISARM, FN_ARM: begin
                                r_state <= S_WR;
                            end
                            FN_ADV: begin
                                r_state <= S_SCAN;
                            end
                            FN_REL: begin
                                if (w_req.movie == 8'd0) begin
                                    r_valid <= '0;
                                    r_state <= S_RESP;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_ALLOC: begin
                    if (r_cnt == CntEnd) begin
                        r_rsp.status <= ST_FULL;
                        r_state      <= S_RESP;
                    end else if (!r_valid[w_cidx]) begin
                        r_valid[w_cidx] <= 1'b1;
                        r_rsp.slot      <= 4'(w_cidx);
                        r_state         <= S_RESP;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_WR: begin
                    if ((r_req.func == FN_ARM) && !w_arm_ok) begin
                        r_rsp.status <= ST_PARAM;
                    end
                    r_state <= S_RESP;
                end
                S_SCAN: begin
                    if (!w_stall) begin
                        if (w_issue) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_s1_vld <= w_issue;
                        r_s1_idx <= w_cidx;
                    end
                    // release: drop matching slots as their entries arrive
                    if (!w_is_adv && r_s1_vld && r_valid[r_s1_idx] &&
                        (w_rdata.movie == r_req.movie)) begin
                        r_valid[r_s1_idx] <= 1'b0;
                    end
                    // advance: hold the newest fired alarm until its last flag is known
                    if (w_fire && !w_stall) begin
                        r_pend     <= '{status: ST_OK, slot: 4'(w_b_idx), fired: 1'b1,
                                        handler: w_b_entry.handler, ctx: w_b_entry.ctx,
                                        last: 1'b0};
                        r_pend_vld <= 1'b1;
                        r_nfire    <= r_nfire + 1'b1;
                    end
                    if (w_done) begin
                        if (r_pend_vld) begin
                            r_rsp      <= '{status: r_pend.status, slot: r_pend.slot,
                                            fired: r_pend.fired, handler: r_pend.handler,
                                            ctx: r_pend.ctx, last: 1'b1};
                            r_pend_vld <= 1'b0;
                        end
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    r_s1_vld <= 1'b0;
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // pack the output word
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {2'b00, r_out.ctx, r_out.handler, r_out.slot, r_out.status};
    assign o_m_axis_tuser  = r_out.fired;
    assign o_m_axis_tlast  = r_out.last;

    // checks
    a_stall_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |-> (r_state == S_SCAN))
        else $error("scan stall outside of an advance");

    a_fire_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfire <= NFW'(MAX_RES))
        else $error("too many alarms fired for one advance");

    a_fire_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && w_fire && !w_stall) |=> r_pend_vld)
        else $error("fired alarm not held for output");

    a_accept_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> (!r_pend_vld && !r_s1_vld))
        else $error("new word accepted with scan results outstanding");

endmodule

// ===== verif/tb_time_crossing_alarm_table.sv =====
// Testbench for time_crossing_alarm_table: directed and random table operations
// checked word by word against an in-bench alarm table predictor.
// Depends on tcat_pkg and the time_crossing_alarm_table RTL.
`timescale 1ns / 1ps

module tb_time_crossing_alarm_table;
    import tcat_pkg::*;

    localparam int NSLOT = 16;
    localparam logic [2:0] FN_BAD6 = 3'd6;
    localparam logic [2:0] FN_BAD7 = 3'd7;

    // idle modes
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [223:0] i_s_axis_tdata;
    logic [2:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [55:0]  o_m_axis_tdata;
    logic [0:0]   o_m_axis_tuser;
    logic         o_m_axis_tlast;

    time_crossing_alarm_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // predicted alarm table
    logic        tbl_valid   [NSLOT];
    logic [7:0]  tbl_movie   [NSLOT];
    logic [15:0] tbl_handler [NSLOT];
    logic [31:0] tbl_ctx     [NSLOT];
    logic [1:0]  tbl_dir     [NSLOT];
    logic [30:0] tbl_time    [NSLOT];
    logic [30:0] tbl_scale   [NSLOT];

    t_rsp pending_rsp[$];
    int   idle_mode = IDLE_NONE;
    int   n_words = 0;
    int   n_rsp = 0;
    int   n_fired = 0;
    int   n_err = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5ms;
        $display("timeout");
        $display("tb_time_crossing_alarm_table NOT OK");
        $finish;
    end

    function automatic t_rsp mk_rsp(logic [1:0] st, logic [3:0] sl, logic fi,
                                    logic [15:0] h, logic [31:0] c, logic lst);
        t_rsp r;
        r.status = st; r.slot = sl; r.fired = fi;
        r.handler = h; r.ctx = c; r.last = lst;
        return r;
    endfunction

    // single status-only result word
    function automatic t_rsp plain_rsp(logic [1:0] st);
        return mk_rsp(st, 4'd0, 1'b0, 16'd0, 32'd0, 1'b1);
    endfunction

    // append one expected result word
    function automatic void queue_rsp(t_rsp r);
        pending_rsp = {pending_rsp, r};
    endfunction

    // update predicted table and queue the expected result words
    task automatic predict_alarms(input t_req q);
        int n;
        int idx;
        longint tgt, prv, cur;
        t_rsp hits[$];
        case (q.func)
            FN_ALLOC: begin
                idx = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (idx < 0 && !tbl_valid[i]) idx = i;
                if (idx < 0) begin
                    queue_rsp(mk_rsp(ST_FULL, 4'd0, 1'b0, 16'd0, 32'd0, 1'b1));
                end else begin
                    tbl_valid[idx] = 1'b1; tbl_movie[idx] = q.movie;
                    tbl_handler[idx] = '0; tbl_ctx[idx] = '0; tbl_dir[idx] = DIR_FWD;
                    tbl_time[idx] = '0; tbl_scale[idx] = 31'd1;
                    queue_rsp(mk_rsp(ST_OK, idx[3:0], 1'b0, 16'd0, 32'd0, 1'b1));
                end
            end
            FN_FREE: begin
                tbl_valid[q.slot] = 1'b0;
                queue_rsp(plain_rsp(ST_OK));
            end
            FN_DISARM: begin
                if (tbl_valid[q.slot]) tbl_handler[q.slot] = '0;
                queue_rsp(plain_rsp(ST_OK));
            end
            FN_ARM: begin
                if (!tbl_valid[q.slot] || q.handler == 16'd0 || $signed(q.ascale) <= 0 ||
                        $signed(q.atime) < 0 || q.dir == DIR_NONE) begin
                    queue_rsp(plain_rsp(ST_PARAM));
                end else begin
                    tbl_handler[q.slot] = q.handler; tbl_ctx[q.slot] = q.ctx;
                    tbl_dir[q.slot] = q.dir; tbl_time[q.slot] = q.atime[30:0];
                    tbl_scale[q.slot] = q.ascale[30:0];
                    queue_rsp(plain_rsp(ST_OK));
                end
            end
            FN_ADV: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (!tbl_valid[i] || tbl_movie[i] != q.movie || tbl_handler[i] == 16'd0 ||
                            tbl_dir[i] == DIR_BACK)
                        continue;
                    tgt = longint'({1'b0, tbl_time[i]}) * longint'({1'b0, q.mscale});
                    prv = longint'($signed(q.start_time)) * longint'({1'b0, tbl_scale[i]});
                    cur = longint'($signed(q.after)) * longint'({1'b0, tbl_scale[i]});
                    if (cur > prv && prv <= tgt && cur >= tgt) begin
                        hits = {hits, mk_rsp(ST_OK, i[3:0], 1'b1, tbl_handler[i],
                                             tbl_ctx[i], 1'b0)};
                        tbl_handler[i] = '0;
                    end
                end
                n = hits.size();
                if (n == 0) begin
                    queue_rsp(plain_rsp(ST_OK));
                end else begin
                    hits[n-1].last = 1'b1;
                    foreach (hits[k]) queue_rsp(hits[k]);
                end
            end
            FN_REL: begin
                for (int i = 0; i < NSLOT; i++)
                    if (q.movie == 8'd0 || (tbl_valid[i] && tbl_movie[i] == q.movie))
                        tbl_valid[i] = 1'b0;
                queue_rsp(plain_rsp(ST_OK));
            end
            default: queue_rsp(plain_rsp(ST_PARAM));
        endcase
    endtask

    // send one request word; tvalid stays high into the next call when no gap falls
    task automatic send_word(input t_req q);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 73 : (idle_mode == IDLE_BOTH) ? 18 : 0;
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = q.func;
        i_s_axis_tdata  = {3'b000, q.mscale, q.after, q.start_time, q.ascale, q.atime,
                           q.dir, q.ctx, q.handler, q.movie, q.slot};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_alarms(q);
        n_words++;
    endtask

    // receiver backpressure
    always @(negedge i_clk) begin
        int st_pct;
        st_pct = (idle_mode == IDLE_RECV) ? 73 : (idle_mode == IDLE_BOTH) ? 18 : 0;
        i_m_axis_tready <= ($urandom_range(99) >= st_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_rsp++;
            if (o_m_axis_tuser[0]) n_fired++;
            if (pending_rsp.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result word %h", o_m_axis_tdata);
            end else begin
                e = pending_rsp.pop_front();
                if (o_m_axis_tdata[1:0] !== e.status || o_m_axis_tdata[5:2] !== e.slot ||
                        o_m_axis_tuser[0] !== e.fired || o_m_axis_tdata[21:6] !== e.handler ||
                        o_m_axis_tdata[53:22] !== e.ctx || o_m_axis_tlast !== e.last) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("mismatch: exp st=%0d sl=%0d f=%0d h=%h c=%h l=%0d",
                                 e.status, e.slot, e.fired, e.handler, e.ctx, e.last);
                        $display("          got st=%0d sl=%0d f=%0d h=%h c=%h l=%0d",
                                 o_m_axis_tdata[1:0], o_m_axis_tdata[5:2],
                                 o_m_axis_tuser[0], o_m_axis_tdata[21:6],
                                 o_m_axis_tdata[53:22], o_m_axis_tlast);
                    end
                end
            end
        end
    end

    function automatic t_req blank_req(logic [2:0] fn);
        t_req q;
        q = '0;
        q.func = fn;
        q.mscale = 31'd1;
        return q;
    endfunction

    task automatic do_arm(input logic [3:0] sl, input logic [15:0] h, input logic [31:0] c,
                          input logic [1:0] d, input logic [31:0] at, input logic [31:0] sc);
        t_req q;
        q = blank_req(FN_ARM);
        q.slot = sl; q.handler = h; q.ctx = c; q.dir = d; q.atime = at; q.ascale = sc;
        send_word(q);
    endtask

    task automatic do_advance(input logic [7:0] mv, input logic [31:0] b, input logic [31:0] a,
                              input logic [30:0] ms);
        t_req q;
        q = blank_req(FN_ADV);
        q.movie = mv; q.start_time = b; q.after = a; q.mscale = ms;
        send_word(q);
    endtask

    task automatic wait_drained();
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    // fill the table and hit full
    task automatic test_alloc_full();
        t_req q;
        for (int i = 0; i < 17; i++) begin
            q = blank_req(FN_ALLOC);
            q.movie = (i < 8) ? 8'd1 : 8'd255;
            send_word(q);
        end
    endtask

    // parameter checks on arm, then firing and the special cases
    task automatic test_arm_advance();
        t_req q;
        do_arm(4'd0, 16'd0, 32'h1, DIR_FWD, 32'd5, 32'd1);            // no handler
        do_arm(4'd0, 16'hFFFF, 32'h1, DIR_NONE, 32'd5, 32'd1);        // no direction
        do_arm(4'd0, 16'h1, 32'h1, DIR_FWD, 32'h8000_0000, 32'd1);    // negative time
        do_arm(4'd0, 16'h1, 32'h1, DIR_FWD, 32'd5, 32'd0);            // zero scale
        do_arm(4'd0, 16'hFFFF, 32'hFFFF_FFFF, DIR_BOTH, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        do_arm(4'd1, 16'h1234, 32'h8000_0000, DIR_FWD, 32'd10, 32'd1);
        do_arm(4'd2, 16'h5678, 32'h0, DIR_BACK, 32'd10, 32'd1);        // backward never fires
        do_arm(4'd8, 16'hABCD, 32'h7FFF_FFFF, DIR_FWD, 32'd0, 32'd1);  // target zero
        do_advance(8'd1, 32'd0, 32'd20, 31'd1);
        do_advance(8'd1, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        do_advance(8'd255, 32'hFFFF_FFF0, 32'd4, 31'd0);               // zero media scale
        q = blank_req(FN_DISARM); q.slot = 4'd0; send_word(q);
        q = blank_req(FN_FREE); q.slot = 4'd1; send_word(q);
        do_arm(4'd1, 16'h1, 32'h1, DIR_FWD, 32'd1, 32'd1);            // arm of a freed slot
        q = blank_req(FN_BAD6); send_word(q);
        q = blank_req(FN_BAD7); send_word(q);
        q = blank_req(FN_REL); q.movie = 8'd1; send_word(q);
        q = blank_req(FN_REL); q.movie = 8'd0; send_word(q);
    endtask

    function automatic logic [31:0] rand_time();
        return ($urandom_range(9) == 0) ? $urandom : $urandom_range(200);
    endfunction

    // random mix weighted toward allocate / arm / advance sequences
    task automatic test_random(input int count, input int mode);
        t_req q;
        int pick;
        idle_mode = mode;
        for (int n = 0; n < count; n++) begin
            q = blank_req(FN_ALLOC);
            q.movie = 8'($urandom_range(1, 3));
            q.slot = 4'($urandom_range(15));
            pick = $urandom_range(99);
            if (pick < 18) begin
                q.func = FN_ALLOC;
            end else if (pick < 26) begin
                q.func = FN_FREE;
            end else if (pick < 31) begin
                q.func = FN_DISARM;
            end else if (pick < 60) begin
                q.func = FN_ARM;
                q.handler = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
                q.ctx = $urandom;
                q.dir = ($urandom_range(19) == 0) ? DIR_NONE : 2'($urandom_range(1, 3));
                q.atime = rand_time();
                q.ascale = ($urandom_range(14) == 0) ? $urandom : $urandom_range(1, 3);
            end else if (pick < 90) begin
                q.func = FN_ADV;
                q.start_time = rand_time();
                q.after = ($urandom_range(9) == 0) ? $urandom :
                          q.start_time + $urandom_range(80);
                q.mscale = ($urandom_range(14) == 0) ? 31'($urandom) : 31'($urandom_range(1, 3));
            end else if (pick < 95) begin
                q.func = FN_REL;
                q.movie = 8'($urandom_range(3));
            end else begin
                // fully random word, any func
                q.func = 3'($urandom); q.slot = 4'($urandom); q.movie = 8'($urandom);
                q.handler = 16'($urandom); q.ctx = $urandom; q.dir = 2'($urandom);
                q.atime = $urandom; q.ascale = $urandom; q.start_time = $urandom;
                q.after = $urandom; q.mscale = 31'($urandom);
            end
            send_word(q);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            tbl_valid[i] = 1'b0; tbl_movie[i] = '0; tbl_handler[i] = '0; tbl_ctx[i] = '0;
            tbl_dir[i] = '0; tbl_time[i] = '0; tbl_scale[i] = '0;
        end
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_alloc_full();
        test_arm_advance();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        wait_drained();
        test_random(50, IDLE_NONE);
        test_random(50, IDLE_SEND);
        test_random(50, IDLE_RECV);
        test_random(50, IDLE_BOTH);

        $display("covered %0d request words, %0d result words (%0d fired alarms)",
                 n_words, n_rsp, n_fired);
        $display("idle phases: none, sender gaps, receiver stalls, both; %0d errors", n_err);
        if (n_err == 0 && pending_rsp.size() == 0)
            $display("tb_time_crossing_alarm_table OK");
        else
            $display("tb_time_crossing_alarm_table NOT OK");
        $finish;
    end

endmodule
